/* rtl/btlv_pkg.sv */
// Shared types and constants for the BER-TLV stream deframer.
// Request and result item structs, result kinds and length-byte codes.
// No dependencies.
package btlv_pkg;

   typedef enum logic [1:0] {
      KIND_VALUE   = 2'd0,
      KIND_EMPTY   = 2'd1,
      KIND_BAD_LEN = 2'd2,
      KIND_TRUNC   = 2'd3
   } kind_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       buffer_end;
   } req_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] tag_value;
      logic        tag_is_two_bytes;
      logic [15:0] element_length;
      logic        value_packed;
      logic [7:0]  value_byte;
      logic        element_last;
   } rsp_type;

   localparam logic [4:0] TAG_EXT_CODE = 5'h1F;
   localparam logic [7:0] LEN_LONG_ONE = 8'h81;
   localparam logic [7:0] LEN_LONG_TWO = 8'h82;

endpackage

/* rtl/ber_tlv_stream_deframer.sv */
// Top level of the BER-TLV stream deframer.
// Instantiates btlv_parse and holds the result register; depends on btlv_pkg.
//
// Usage:
//   req_valid/req_ready/req_item carry one buffer byte per item, with
//   buffer_end marking the final byte of a buffer. rsp_valid/rsp_ready/rsp_item
//   carry at most one result per byte: a value byte with its element's tag,
//   length and packed flag, an empty-element marker, a bad-length marker or a
//   truncation marker.
//   Output: a result appears on rsp_ in the cycle after the byte that causes it
//   is accepted. Throughput: one byte per cycle unless a held result stalls;
//   parse state and result are updated in the same cycle as the byte is taken.
//   Stall: a held result keeps req_ready low only while rsp_ready is low;
//   when rsp_ready is high the next byte is taken in the same cycle as the
//   result leaves, so a full stream runs at one byte per clock.
//   Reset: synchronous, active high; clears the result valid flag and returns
//   the parser to expecting the first tag byte with tag, length and count zero.
module ber_tlv_stream_deframer
   import btlv_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_item,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_item
);

   logic    accept;
   logic    step_valid;
   rsp_type step_item;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_item_ff;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   btlv_parse u_parse (
      .clock        (clock),
      .reset        (reset),
      .step_en      (accept),
      .step_item    (req_item),
      .result_valid (step_valid),
      .result_item  (step_item)
   );

   // load on accept; otherwise hold until taken
   assign rsp_valid_in = accept ? step_valid : (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && step_valid) begin
         rsp_item_ff <= step_item;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   property p_result_registered;
      @(posedge clock) disable iff (reset)
         accept && step_valid |=> rsp_valid_ff;
   endproperty
   a_result_registered: assert property (p_result_registered)
      else $error("accepted byte with a result did not present it");

   property p_marker_fields;
      @(posedge clock) disable iff (reset)
         rsp_valid_ff && rsp_item_ff.kind != KIND_VALUE
            |-> rsp_item_ff.element_last && rsp_item_ff.value_byte == 8'd0;
   endproperty
   a_marker_fields: assert property (p_marker_fields)
      else $error("marker result carries a value byte or lacks element_last");

   property p_empty_length;
      @(posedge clock) disable iff (reset)
         rsp_valid_ff && rsp_item_ff.kind == KIND_EMPTY
            |-> rsp_item_ff.element_length == 16'd0;
   endproperty
   a_empty_length: assert property (p_empty_length)
      else $error("empty element reported with nonzero length");

   property p_no_result_no_valid;
      @(posedge clock) disable iff (reset)
         accept && !step_valid |=> !rsp_valid_ff;
   endproperty
   a_no_result_no_valid: assert property (p_no_result_no_valid)
      else $error("byte without a result produced an output item");

endmodule

/* rtl/btlv_parse.sv */
// Parse state machine of the BER-TLV deframer: one byte per step.
// Holds phase, tag, length and value countdown; forms the result item combinationally.
// Depends on btlv_pkg.
module btlv_parse
   import btlv_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    step_en,
   input  req_type step_item,
   output logic    result_valid,
   output rsp_type result_item
);

   typedef enum logic [2:0] {
      PH_TAG1, PH_TAG2, PH_LEN1, PH_L81, PH_L82H, PH_L82L, PH_VALUE, PH_WAIT
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [15:0] tag_ff, tag_in;
   logic        two_ff, two_in;
   logic [15:0] len_ff, len_in;
   logic        packed_ff, packed_in;
   logic [15:0] left_ff, left_in;

   logic [7:0]  b;
   logic        last_byte;
   logic        len_done;
   logic        chk_end;
   logic [15:0] left_next;
   logic [16:0] len_inc;
   kind_type    kind;
   logic [7:0]  vbyte;
   logic        elast;

   assign b         = step_item.data_byte;
   assign last_byte = step_item.buffer_end;
   assign left_next = (left_ff == 16'd0) ? 16'd0 : left_ff - 16'd1;
   assign len_inc   = {1'b0, len_in} + 17'd1;

   always_comb begin
      phase_in     = phase_ff;
      tag_in       = tag_ff;
      two_in       = two_ff;
      len_in       = len_ff;
      packed_in    = packed_ff;
      left_in      = left_ff;
      result_valid = 1'b0;
      kind         = KIND_VALUE;
      vbyte        = 8'd0;
      elast        = 1'b0;
      len_done     = 1'b0;
      chk_end      = 1'b0;

      unique case (phase_ff)
         PH_TAG1: begin
            tag_in    = {8'd0, b};
            two_in    = 1'b0;
            len_in    = 16'd0;
            packed_in = 1'b0;
            left_in   = 16'd0;
            phase_in  = (b[4:0] == TAG_EXT_CODE) ? PH_TAG2 : PH_LEN1;
            chk_end   = 1'b1;
         end
         PH_TAG2: begin
            tag_in   = {tag_ff[7:0], b};
            two_in   = 1'b1;
            phase_in = PH_LEN1;
            chk_end  = 1'b1;
         end
         PH_LEN1: begin
            if (!b[7]) begin
               len_in    = {8'd0, b};
               packed_in = 1'b0;
               len_done  = 1'b1;
            end else if (b == LEN_LONG_ONE) begin
               packed_in = 1'b1;
               phase_in  = PH_L81;
               chk_end   = 1'b1;
            end else if (b == LEN_LONG_TWO) begin
               packed_in = 1'b1;
               phase_in  = PH_L82H;
               chk_end   = 1'b1;
            end else begin
               // bad length byte: report once, then skip to end of buffer
               result_valid = 1'b1;
               kind         = KIND_BAD_LEN;
               elast        = 1'b1;
               phase_in     = last_byte ? PH_TAG1 : PH_WAIT;
            end
         end
         PH_L81: begin
            len_in   = {8'd0, b};
            len_done = 1'b1;
         end
         PH_L82H: begin
            len_in   = {b, 8'd0};
            phase_in = PH_L82L;
            chk_end  = 1'b1;
         end
         PH_L82L: begin
            len_in   = {len_ff[15:8], b};
            len_done = 1'b1;
         end
         PH_VALUE: begin
            left_in      = left_next;
            result_valid = 1'b1;
            if (left_next == 16'd0) begin
               phase_in = PH_TAG1;
               vbyte    = b;
               elast    = 1'b1;
            end else if (last_byte) begin
               phase_in = PH_TAG1;
               kind     = KIND_TRUNC;
               elast    = 1'b1;
            end else begin
               vbyte = b;
            end
         end
         PH_WAIT: begin
            if (last_byte) phase_in = PH_TAG1;
         end
      endcase

      if (len_done) begin
         // packed BCD: digit count rounds up to whole bytes
         left_in = packed_in ? len_inc[16:1] : len_in;
         if (len_in == 16'd0) begin
            phase_in     = PH_TAG1;
            result_valid = 1'b1;
            kind         = KIND_EMPTY;
            elast        = 1'b1;
         end else if (last_byte) begin
            phase_in     = PH_TAG1;
            result_valid = 1'b1;
            kind         = KIND_TRUNC;
            elast        = 1'b1;
         end else begin
            phase_in = PH_VALUE;
         end
      end

      if (chk_end && last_byte) begin
         phase_in     = PH_TAG1;
         result_valid = 1'b1;
         kind         = KIND_TRUNC;
         elast        = 1'b1;
      end
   end

   always_comb begin
      result_item.kind             = kind;
      result_item.tag_value        = tag_in;
      result_item.tag_is_two_bytes = two_in;
      result_item.element_length   = len_in;
      result_item.value_packed     = packed_in;
      result_item.value_byte       = vbyte;
      result_item.element_last     = elast;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_TAG1;
         tag_ff    <= 16'd0;
         two_ff    <= 1'b0;
         len_ff    <= 16'd0;
         packed_ff <= 1'b0;
         left_ff   <= 16'd0;
      end else if (step_en) begin
         phase_ff  <= phase_in;
         tag_ff    <= tag_in;
         two_ff    <= two_in;
         len_ff    <= len_in;
         packed_ff <= packed_in;
         left_ff   <= left_in;
      end
   end

   property p_value_phase_counts;
      @(posedge clock) disable iff (reset)
         phase_ff == PH_VALUE |-> left_ff != 16'd0;
   endproperty
   a_value_phase_counts: assert property (p_value_phase_counts)
      else $error("value phase entered with no bytes left");

endmodule
